// File: sv/sorted_array_priority_queue_unit_defines.svh
// Assertion macros shared by the sorted array priority queue RTL.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/sapq_pkg.sv
// Types and constants of the sorted array priority queue.
// Used by sapq_core and sorted_array_priority_queue_unit; depends on nothing.
package sapq_pkg;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [3:0]         occupancy;
	} rsp_t;

	// Handshake between the sequencer core and the output stage.
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

endpackage

// File: sv/sapq_core.sv
// Sequencer, sorted storage and shared comparator of the priority queue.
// Depends on sapq_pkg and sorted_array_priority_queue_unit_defines.svh.
`include "sorted_array_priority_queue_unit_defines.svh"

module sapq_core #(
	parameter int DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  sapq_pkg::req_t        req,
	input  logic                  take,
	output sapq_pkg::core_stat_t  stat,
	output sapq_pkg::rsp_t        rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_INS_RD  = 7'b0000010,
		ST_INS_CMP = 7'b0000100,
		ST_INS_PUT = 7'b0001000,
		ST_REM_RD  = 7'b0010000,
		ST_REM_SH  = 7'b0100000,
		ST_FIN     = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      pos_q;
	logic signed [31:0] val_q;
	logic [31:0]        rd_data_q;
	logic signed [31:0] removed_q;
	logic [1:0]         status_q;

	logic [31:0]   mem [DEPTH];
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;

	logic          greater;
	logic          full;
	logic          empty;
	logic [AW-1:0] last_idx;

	// The one comparator: is the entry just read ordered after the new value?
	assign greater  = $signed(rd_data_q) > val_q;
	assign full     = count_q == CW'(DEPTH);
	assign empty    = count_q == '0;
	assign last_idx = AW'(count_q - CW'(1));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = rd_data_q;
		rd_addr = pos_q;
		case (state_q)
			ST_IDLE: begin
				if (start && req.mode == sapq_pkg::MODE_INSERT && empty) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = req.value;
				end
			end
			ST_INS_RD: begin
				rd_addr = pos_q - AW'(1);
			end
			ST_INS_CMP: begin
				// Either move the larger entry up one slot or drop the new value in.
				wr_en = 1'b1;
				if (!greater) begin
					wr_data = val_q;
				end
			end
			ST_INS_PUT: begin
				wr_en   = 1'b1;
				wr_data = val_q;
			end
			ST_REM_SH: begin
				if (pos_q != '0) begin
					wr_en   = 1'b1;
					wr_addr = pos_q - AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (req.mode == sapq_pkg::MODE_INSERT) begin
							if (full) begin
								state_q <= ST_FIN;
							end else if (empty) begin
								count_q <= CW'(1);
								state_q <= ST_FIN;
							end else begin
								pos_q   <= AW'(count_q);
								state_q <= ST_INS_RD;
							end
						end else begin
							if (empty) begin
								state_q <= ST_FIN;
							end else begin
								pos_q   <= '0;
								state_q <= ST_REM_RD;
							end
						end
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS_CMP;
				end
				ST_INS_CMP: begin
					if (greater) begin
						pos_q   <= pos_q - AW'(1);
						state_q <= (pos_q == AW'(1)) ? ST_INS_PUT : ST_INS_RD;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_FIN;
					end
				end
				ST_INS_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_FIN;
				end
				ST_REM_RD: begin
					state_q <= ST_REM_SH;
				end
				ST_REM_SH: begin
					if (pos_q == last_idx) begin
						count_q <= count_q - CW'(1);
						state_q <= ST_FIN;
					end else begin
						pos_q   <= pos_q + AW'(1);
						state_q <= ST_REM_RD;
					end
				end
				ST_FIN: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			val_q     <= req.value;
			removed_q <= '0;
			if (req.mode == sapq_pkg::MODE_INSERT) begin
				status_q <= full ? sapq_pkg::STATUS_FULL : sapq_pkg::STATUS_OK;
			end else begin
				status_q <= empty ? sapq_pkg::STATUS_EMPTY : sapq_pkg::STATUS_OK;
			end
		end else if (state_q == ST_REM_SH && pos_q == '0) begin
			removed_q <= $signed(rd_data_q);
		end
	end

	assign stat.busy         = state_q != ST_IDLE;
	assign stat.done         = state_q == ST_FIN;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q;
	assign rsp.occupancy     = 4'(count_q);

	`SAPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count exceeds depth")
	`SAPQ_ASSERT_NOW(a_start_idle, start, state_q == ST_IDLE, "start while busy")
	`SAPQ_ASSERT_NEXT(a_done_holds, stat.done && !take, stat.done, "result dropped")
	`SAPQ_ASSERT_NOW(a_fail_zero, stat.done && status_q != sapq_pkg::STATUS_OK,
		removed_q == '0, "failed operation returned a value")
	`SAPQ_ASSERT_NOW(a_full_count, stat.done && status_q == sapq_pkg::STATUS_FULL,
		count_q == CW'(DEPTH), "full status without a full store")

endmodule

// File: sv/sorted_array_priority_queue_unit.sv
// Sorted array min-priority queue: up to DEPTH signed 32-bit values kept in
// ascending order in a store with one read and one write port, walked by one
// comparator. An insert into a full or empty queue, or a remove from an empty
// one, goes straight to the result; else an insert moves the larger entries up
// and drops the new value in, and a remove shifts the rest down. Each moved
// entry costs one read and one write of the store. The request channel stalls
// while an item is in work; one result beat comes out per request beat, through
// an output register. Depends on sapq_pkg and sapq_core.
module sorted_array_priority_queue_unit #(
	parameter int DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sapq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sapq_pkg::rsp_t rsp
);

	sapq_pkg::core_stat_t core_stat;
	sapq_pkg::rsp_t       core_rsp;
	logic                 start;
	logic                 take;
	logic                 rsp_valid_q;
	sapq_pkg::rsp_t       rsp_q;

	assign req_stall = core_stat.busy;
	assign start     = req_valid && !core_stat.busy;
	// The output register can load when it is empty or its beat leaves now.
	assign take      = !rsp_valid_q || !rsp_stall;

	sapq_core #(
		.DEPTH(DEPTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.take  (take),
		.stat  (core_stat),
		.rsp   (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (core_stat.done && take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_stat.done && take) begin
			rsp_q <= core_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the sorted array min-priority queue unit.
// A scoreboard class tracks the held values and the expected result beats.
// Depends on sapq_pkg and sorted_array_priority_queue_unit.

class sapq_scoreboard;
	int                 capacity;
	int                 errors;
	logic signed [31:0] held_values[$];
	sapq_pkg::rsp_t     pending_rsps[$];

	function new(int cap);
		capacity = cap;
		errors = 0;
	endfunction

	task report(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function int pending();
		return pending_rsps.size();
	endfunction

	// Work out the result of one accepted request beat and update the held values.
	function void note_request(sapq_pkg::req_t item);
		sapq_pkg::rsp_t     want;
		int                 pos;
		logic signed [31:0] v;
		v = $signed(item.value);
		want.status = sapq_pkg::STATUS_OK;
		want.removed_value = '0;
		if (item.mode == sapq_pkg::MODE_INSERT) begin
			if (held_values.size() >= capacity) begin
				want.status = sapq_pkg::STATUS_FULL;
			end else begin
				// A new value goes after any equal values already held.
				pos = held_values.size();
				while (pos > 0 && held_values[pos - 1] > v)
					pos--;
				held_values.insert(pos, v);
			end
		end else begin
			if (held_values.size() == 0)
				want.status = sapq_pkg::STATUS_EMPTY;
			else
				want.removed_value = held_values.pop_front();
		end
		want.occupancy = 4'(held_values.size());
		pending_rsps.push_back(want);
	endfunction

	task check_response(sapq_pkg::rsp_t got);
		sapq_pkg::rsp_t want;
		if (pending_rsps.size() == 0) begin
			report($sformatf("result beat with nothing expected: status %0d value %0d occ %0d",
				got.status, $signed(got.removed_value), got.occupancy));
		end else begin
			want = pending_rsps.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.removed_value !== want.removed_value)
				report($sformatf("removed_value %0d, expected %0d",
					$signed(got.removed_value), $signed(want.removed_value)));
			if (got.occupancy !== want.occupancy)
				report($sformatf("occupancy %0d, expected %0d", got.occupancy, want.occupancy));
		end
	endtask
endclass

module tb_top;

	localparam int QUEUE_DEPTH = 8;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	sapq_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	sapq_pkg::rsp_t rsp;

	sapq_scoreboard sb = new(QUEUE_DEPTH);

	bit no_gaps = 1'b0;
	int stall_hold = 0;

	sorted_array_priority_queue_unit #(
		.DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #1 clk = ~clk;

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	function logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $urandom;
		else if (r < 70)
			return $urandom_range(0, 15) - 8;
		else if (r < 85)
			return VAL_MIN + $urandom_range(0, 3);
		else
			return VAL_MAX - $urandom_range(0, 3);
	endfunction

	// Present one request beat after a random gap and hold it until it is taken.
	task send(logic m, logic signed [31:0] v);
		sapq_pkg::req_t item;
		int             gap;
		item.mode = m;
		item.value = v;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(item);
	endtask

	// Result side: check accepted beats, then hold the current stall or pick a new one.
	always @(posedge clk) begin
		int r;
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
		if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				rsp_stall <= 1'b0;
				stall_hold = $urandom_range(0, 3);
			end else if (r < 80) begin
				rsp_stall <= 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else if (r < 92) begin
				rsp_stall <= 1'b1;
				stall_hold = $urandom_range(4, 14);
			end else if (r < 96) begin
				rsp_stall <= 1'b1;
				stall_hold = $urandom_range(19, 39);
			end else begin
				rsp_stall <= 1'b0;
				stall_hold = $urandom_range(29, 79);
			end
		end
	end

	initial begin
		int insert_pct;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty remove, extremes, equal values, full and drain.
		send(sapq_pkg::MODE_REMOVE, 32'sh0);
		send(sapq_pkg::MODE_INSERT, 32'sh0);
		send(sapq_pkg::MODE_INSERT, VAL_MAX);
		send(sapq_pkg::MODE_INSERT, VAL_MIN);
		send(sapq_pkg::MODE_INSERT, -32'sd1);
		send(sapq_pkg::MODE_INSERT, 32'sd5);
		send(sapq_pkg::MODE_INSERT, 32'sd5);
		send(sapq_pkg::MODE_INSERT, 32'sd1);
		send(sapq_pkg::MODE_INSERT, VAL_MIN + 32'sd1);
		send(sapq_pkg::MODE_INSERT, 32'sd3);
		send(sapq_pkg::MODE_REMOVE, 32'shffff_ffff);
		send(sapq_pkg::MODE_INSERT, VAL_MIN);
		send(sapq_pkg::MODE_INSERT, VAL_MAX);
		repeat (QUEUE_DEPTH) send(sapq_pkg::MODE_REMOVE, 32'sh5555_5555);
		send(sapq_pkg::MODE_REMOVE, 32'shaaaa_aaaa);
		send(sapq_pkg::MODE_INSERT, 32'shaaaa_aaaa);
		send(sapq_pkg::MODE_INSERT, 32'sh5555_5555);
		send(sapq_pkg::MODE_REMOVE, 32'sh0);
		send(sapq_pkg::MODE_REMOVE, VAL_MIN);
		send(sapq_pkg::MODE_REMOVE, VAL_MAX);

		// Random part: segments lean toward filling or draining so that
		// both the full and the empty cases come up often.
		insert_pct = 50;
		for (int n = 0; n < 400; n++) begin
			if (n % 20 == 0) begin
				case ($urandom_range(0, 3))
					0: insert_pct = 20;
					1: insert_pct = 50;
					2: insert_pct = 80;
					default: insert_pct = 95;
				endcase
			end
			if (n % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < insert_pct)
				send(sapq_pkg::MODE_INSERT, pick_value());
			else
				send(sapq_pkg::MODE_REMOVE, $urandom);
		end
		req_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/sapq_pkg.sv
sv/sapq_core.sv
sv/sorted_array_priority_queue_unit.sv
bench/tb_top.sv
